// ----- hw/rtl/ale_pkg.sv -----
// Shared constants, codes and control structs of the adjacency-list edge store.
`default_nettype none

package ale_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int MAX_DEGREE_DEF   = 8;

    localparam int ACT_W    = 2;
    localparam int VERT_W   = 4;
    localparam int WGT_W    = 16;
    localparam int SLOT_W   = 3;
    localparam int STAT_W   = 3;
    localparam int DEGO_W   = 4;
    localparam int VCOUNT_W = 5;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 5'd16;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANGE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_MISSING = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;

    // register select, from paddr[2]
    localparam logic REG_VCOUNT   = 1'b0;
    localparam logic REG_WEIGHTED = 1'b1;

    typedef struct packed {
        logic              load;
        logic              side;        // 0 list of from_vertex, 1 list of to_vertex
        logic              deg_rd;
        logic              cap_a;
        logic              cap_b;
        logic              append;
        logic              scan_start;
        logic              scan_step;
        logic              move_rd;
        logic              move_wr;
        logic              slot_rd;
        logic              finish;
        logic [STAT_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             directed;
        logic             from_ok;
        logic             to_ok;
        logic             full;
        logic             slot_empty;
        logic             hit;
        logic             miss;
        logic             out_busy;
    } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ale_cfg.sv -----
// APB configuration registers: vertex count and weighted mode.
`default_nettype none

module ale_cfg
    import ale_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output logic      [VCOUNT_W-1:0] vertex_count,
    output logic                     weighted
);

    logic [VCOUNT_W-1:0] vcount_reg;
    logic                weighted_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg   <= VCOUNT_RST;
            weighted_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_VCOUNT:   vcount_reg   <= pwdata[VCOUNT_W-1:0];
                REG_WEIGHTED: weighted_reg <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_VCOUNT:   prdata = {{(32-VCOUNT_W){1'b0}}, vcount_reg};
            REG_WEIGHTED: prdata = {31'b0, weighted_reg};
            default:      prdata = '0;
        endcase
    end

    assign vertex_count = vcount_reg;
    assign weighted     = weighted_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ale_dpath.sv -----
// Datapath: degree memory, neighbour and weight memories, list scan and result register.
`default_nettype none

module ale_dpath
    import ale_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic        [ACT_W-1:0]    action,
    input  wire logic        [VERT_W-1:0]   from_vertex,
    input  wire logic        [VERT_W-1:0]   to_vertex,
    input  wire logic                       directed,
    input  wire logic signed [WGT_W-1:0]    edge_weight,
    input  wire logic        [SLOT_W-1:0]   slot_index,
    input  wire logic        [VCOUNT_W-1:0] vertex_count,
    input  wire logic                       weighted,
    input  wire cmd_t                       cmd,
    output stat_t                           stat,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic             [STAT_W-1:0]   status,
    output logic             [VERT_W-1:0]   neighbour,
    output logic signed      [WGT_W-1:0]    weight_out,
    output logic             [DEGO_W-1:0]   degree_out
);

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int DEPTH = MAX_VERTICES * MAX_DEGREE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int GW    = $clog2(MAX_DEGREE + 1);
    localparam int CW    = (GW > SLOT_W) ? GW : SLOT_W;
    localparam logic [GW:0] DEG_LIMIT = (GW+1)'(MAX_DEGREE);

    function automatic logic [AW-1:0] slot_addr(input logic [VW-1:0] v, input logic [SW-1:0] s);
        return AW'(v) * AW'(MAX_DEGREE) + AW'(s);
    endfunction

    // latched item
    logic [ACT_W-1:0]  act_reg;
    logic [VERT_W-1:0] from_reg;
    logic [VERT_W-1:0] to_reg;
    logic              dir_reg;
    logic [WGT_W-1:0]  wgt_reg;
    logic [SLOT_W-1:0] slot_reg;

    // working degrees and scan
    logic [GW-1:0] deg_a_reg;
    logic [GW-1:0] deg_b_reg;
    logic [GW-1:0] scan_idx_reg;
    logic [SW-1:0] pend_idx_reg;
    logic          pend_reg;
    logic          scan_side_reg;

    // memories
    logic [GW-1:0]           deg_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] deg_vld_reg;
    logic [GW-1:0]           deg_rd_reg;
    logic                    deg_rd_vld_reg;
    logic [VERT_W-1:0]       nb_mem  [DEPTH];
    logic [WGT_W-1:0]        wgt_mem [DEPTH];
    logic [VERT_W-1:0]       nb_rd_reg;
    logic [WGT_W-1:0]        wgt_rd_reg;

    // result
    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic [VERT_W-1:0] nb_out_reg;
    logic [WGT_W-1:0]  wgt_out_reg;
    logic [DEGO_W-1:0] deg_out_reg;

    logic [VW-1:0]     from_v;
    logic [VW-1:0]     to_v;
    logic [VW-1:0]     app_v;
    logic [VW-1:0]     scan_v;
    logic [GW-1:0]     app_deg;
    logic [GW-1:0]     scan_deg;
    logic [GW-1:0]     deg_rd_val;
    logic [VERT_W-1:0] scan_target;
    logic              same_vertex;
    logic              scan_more;
    logic              from_ok;
    logic              to_ok;
    logic              rd_ok;
    logic [GW-1:0]     deg_next;
    logic              deg_we;
    logic [VW-1:0]     deg_waddr;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [VERT_W-1:0] nb_wdata;
    logic [WGT_W-1:0]  wgt_wdata;

    assign from_v      = VW'(from_reg);
    assign to_v        = VW'(to_reg);
    assign same_vertex = (from_reg == to_reg);
    assign app_v       = cmd.side ? to_v : from_v;
    assign app_deg     = cmd.side ? deg_b_reg : deg_a_reg;
    assign scan_v      = scan_side_reg ? to_v : from_v;
    assign scan_deg    = scan_side_reg ? deg_b_reg : deg_a_reg;
    assign scan_target = scan_side_reg ? from_reg : to_reg;
    assign scan_more   = (scan_idx_reg < scan_deg);
    assign deg_rd_val  = deg_rd_vld_reg ? deg_rd_reg : '0;

    assign from_ok = (VCOUNT_W'(from_reg) < vertex_count) && (32'(from_reg) < MAX_VERTICES);
    assign to_ok   = (VCOUNT_W'(to_reg) < vertex_count) && (32'(to_reg) < MAX_VERTICES);
    assign rd_ok   = (act_reg == ACT_READ) && (cmd.code == ST_OK);

    always_comb
    begin
        stat.action     = act_reg;
        stat.directed   = dir_reg;
        stat.from_ok    = from_ok;
        stat.to_ok      = to_ok;
        stat.full       = (((GW+1)'(deg_a_reg) + ((!dir_reg && same_vertex) ? (GW+1)'(2)
                                                                             : (GW+1)'(1)))
                           > DEG_LIMIT)
                          || (!dir_reg && !same_vertex
                              && (((GW+1)'(deg_b_reg) + (GW+1)'(1)) > DEG_LIMIT));
        stat.slot_empty = CW'(slot_reg) >= CW'(deg_a_reg);
        stat.hit        = pend_reg && (nb_rd_reg == scan_target);
        stat.miss       = !pend_reg && !scan_more;
        stat.out_busy   = out_valid_reg && !out_ready;
    end

    // memory port selection
    always_comb
    begin
        deg_we    = 1'b0;
        deg_waddr = app_v;
        deg_next  = app_deg + GW'(1);
        mem_re    = 1'b0;
        mem_raddr = slot_addr(scan_v, SW'(scan_idx_reg));
        mem_we    = 1'b0;
        mem_waddr = slot_addr(app_v, SW'(app_deg));
        nb_wdata  = cmd.side ? from_reg : to_reg;
        wgt_wdata = wgt_reg;
        if (cmd.append)
        begin
            deg_we = 1'b1;
            mem_we = 1'b1;
        end
        if (cmd.scan_step)
        begin
            mem_re = scan_more;
        end
        if (cmd.move_rd)
        begin
            deg_we    = 1'b1;
            deg_waddr = scan_v;
            deg_next  = scan_deg - GW'(1);
            mem_re    = 1'b1;
            mem_raddr = slot_addr(scan_v, SW'(scan_deg - GW'(1)));
        end
        if (cmd.move_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = slot_addr(scan_v, pend_idx_reg);
            nb_wdata  = nb_rd_reg;
            wgt_wdata = wgt_rd_reg;
        end
        if (cmd.slot_rd)
        begin
            mem_re    = 1'b1;
            mem_raddr = slot_addr(from_v, SW'(slot_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            from_reg <= from_vertex;
            to_reg   <= to_vertex;
            dir_reg  <= directed;
            wgt_reg  <= edge_weight;
            slot_reg <= slot_index;
        end
        if (cmd.cap_a)
        begin
            deg_a_reg <= deg_rd_val;
        end
        if (cmd.cap_b)
        begin
            deg_b_reg <= deg_rd_val;
        end
        if (cmd.append)
        begin
            if (same_vertex || !cmd.side)
            begin
                deg_a_reg <= deg_next;
            end
            if (same_vertex || cmd.side)
            begin
                deg_b_reg <= deg_next;
            end
        end
        if (cmd.move_rd)
        begin
            if (same_vertex || !scan_side_reg)
            begin
                deg_a_reg <= deg_next;
            end
            if (same_vertex || scan_side_reg)
            begin
                deg_b_reg <= deg_next;
            end
        end
        if (cmd.scan_start)
        begin
            scan_idx_reg  <= '0;
            scan_side_reg <= cmd.side;
        end
        else if (cmd.scan_step)
        begin
            pend_idx_reg <= SW'(scan_idx_reg);
            if (scan_more)
            begin
                scan_idx_reg <= scan_idx_reg + GW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            pend_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            pend_reg <= scan_more;
        end
    end

    // degree memory, entries read as zero until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_vld_reg <= '0;
        end
        else if (deg_we)
        begin
            deg_vld_reg[deg_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_next;
        end
        if (cmd.deg_rd)
        begin
            deg_rd_reg     <= deg_mem[app_v];
            deg_rd_vld_reg <= deg_vld_reg[app_v];
        end
    end

    // neighbour and weight memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            nb_mem[mem_waddr] <= nb_wdata;
            if (weighted)
            begin
                wgt_mem[mem_waddr] <= wgt_wdata;
            end
        end
        if (mem_re)
        begin
            nb_rd_reg  <= nb_mem[mem_raddr];
            wgt_rd_reg <= wgt_mem[mem_raddr];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg  <= cmd.code;
            nb_out_reg  <= rd_ok ? nb_rd_reg : '0;
            wgt_out_reg <= (rd_ok && weighted) ? wgt_rd_reg : '0;
            deg_out_reg <= from_ok ? DEGO_W'(deg_a_reg) : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign neighbour  = nb_out_reg;
    assign weight_out = wgt_out_reg;
    assign degree_out = deg_out_reg;

`ifndef SYNTH
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> (app_deg < GW'(MAX_DEGREE)))
        else $error("append into a full list");

    a_move_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move_rd |-> (stat.hit && (scan_deg != '0)))
        else $error("entry move without a matching slot");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && !out_ready))
        else $error("result overwrites an untaken result");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |=> (scan_idx_reg <= scan_deg))
        else $error("scan index past list end");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/ale_ctrl.sv -----
// Controller: sequences degree reads, appends, list scans, entry moves and result transfer.
`default_nettype none

module ale_ctrl
    import ale_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DEG_A    = 4'd1;
    localparam logic [3:0] S_DEG_B    = 4'd2;
    localparam logic [3:0] S_DEG_C    = 4'd3;
    localparam logic [3:0] S_DECIDE   = 4'd4;
    localparam logic [3:0] S_APPEND_A = 4'd5;
    localparam logic [3:0] S_APPEND_B = 4'd6;
    localparam logic [3:0] S_SCAN_A   = 4'd7;
    localparam logic [3:0] S_MOVRD_A  = 4'd8;
    localparam logic [3:0] S_MOVWR_A  = 4'd9;
    localparam logic [3:0] S_SCAN_B   = 4'd10;
    localparam logic [3:0] S_MOVRD_B  = 4'd11;
    localparam logic [3:0] S_MOVWR_B  = 4'd12;
    localparam logic [3:0] S_SLOT_RD  = 4'd13;
    localparam logic [3:0] S_FINISH   = 4'd14;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [STAT_W-1:0] code_reg;
    logic [STAT_W-1:0] code_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_DEG_A;
                end
            end
            S_DEG_A:
            begin
                cmd.deg_rd = 1'b1;
                state_next = S_DEG_B;
            end
            S_DEG_B:
            begin
                cmd.cap_a  = 1'b1;
                cmd.side   = 1'b1;
                cmd.deg_rd = 1'b1;
                state_next = S_DEG_C;
            end
            S_DEG_C:
            begin
                cmd.cap_b  = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                code_next  = ST_OK;
                state_next = S_FINISH;
                case (stat.action)
                    ACT_INSERT:
                    begin
                        if (!stat.from_ok || !stat.to_ok)
                        begin
                            code_next = ST_RANGE;
                        end
                        else if (stat.full)
                        begin
                            code_next = ST_FULL;
                        end
                        else
                        begin
                            state_next = S_APPEND_A;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (!stat.from_ok || !stat.to_ok)
                        begin
                            code_next = ST_RANGE;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN_A;
                        end
                    end
                    ACT_READ:
                    begin
                        if (!stat.from_ok)
                        begin
                            code_next = ST_RANGE;
                        end
                        else if (stat.slot_empty)
                        begin
                            code_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_SLOT_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_APPEND_A:
            begin
                cmd.append = 1'b1;
                state_next = stat.directed ? S_FINISH : S_APPEND_B;
            end
            S_APPEND_B:
            begin
                cmd.append = 1'b1;
                cmd.side   = 1'b1;
                state_next = S_FINISH;
            end
            S_SCAN_A:
            begin
                if (stat.hit)
                begin
                    state_next = S_MOVRD_A;
                end
                else if (stat.miss)
                begin
                    code_next  = ST_MISSING;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_MOVRD_A:
            begin
                cmd.move_rd = 1'b1;
                state_next  = S_MOVWR_A;
            end
            S_MOVWR_A:
            begin
                cmd.move_wr = 1'b1;
                if (stat.directed)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.side       = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN_B;
                end
            end
            S_SCAN_B:
            begin
                if (stat.hit)
                begin
                    state_next = S_MOVRD_B;
                end
                else if (stat.miss)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_MOVRD_B:
            begin
                cmd.move_rd = 1'b1;
                state_next  = S_MOVWR_B;
            end
            S_MOVWR_B:
            begin
                cmd.move_wr = 1'b1;
                state_next  = S_FINISH;
            end
            S_SLOT_RD:
            begin
                cmd.slot_rd = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/adjacency_list_edge_store.sv -----
// Top level of the adjacency-list edge store: stream ports, APB port, controller and datapath.
//
// channel   | handshake                        | payload
// ----------+----------------------------------+---------------------------------------------
// s_axis    | s_axis_tvalid / s_axis_tready    | tuser: action; tdata: from, to, dir, wgt, slot
// m_axis    | m_axis_tvalid / m_axis_tready    | tuser: status; tdata: neighbour, weight, degree
// apb       | psel & penable & pwrite (pready) | 0x0 vertex_count, 0x4 weighted
//
// One item at a time: degree reads (S_DEG_A to S_DEG_C), then S_DECIDE, which sends a rejected
// item or the unused action straight to S_FINISH, a read through S_SLOT_RD, an insert through one
// append (two if undirected) and a remove through a one-slot-per-cycle scan of the from list and,
// for an undirected edge found there, of the to list. s_axis_tready rises with m_axis_tvalid.
// Reset clears the degree valid bits at once; no clearing pass.
// A new item is taken while a result waits on m_axis; its own result waits behind it.
`default_nettype none

module adjacency_list_edge_store
    import ale_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // from[3:0] to[7:4] directed[8] weight[24:9] slot[27:25]
    input  wire logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // neighbour[3:0] weight_out[19:4] degree_out[23:20]
    output logic [2:0]       m_axis_tuser,   // status[2:0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cmd_t                     cmd;
    stat_t                    stat;
    logic [VCOUNT_W-1:0]      vertex_count;
    logic                     weighted;
    logic [STAT_W-1:0]        status;
    logic [VERT_W-1:0]        neighbour;
    logic signed [WGT_W-1:0]  weight_out;
    logic [DEGO_W-1:0]        degree_out;

    ale_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .vertex_count (vertex_count),
        .weighted     (weighted)
    );

    ale_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ale_dpath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .action       (s_axis_tuser),
        .from_vertex  (s_axis_tdata[3:0]),
        .to_vertex    (s_axis_tdata[7:4]),
        .directed     (s_axis_tdata[8]),
        .edge_weight  ($signed(s_axis_tdata[24:9])),
        .slot_index   (s_axis_tdata[27:25]),
        .vertex_count (vertex_count),
        .weighted     (weighted),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .status       (status),
        .neighbour    (neighbour),
        .weight_out   (weight_out),
        .degree_out   (degree_out)
    );

    assign m_axis_tdata = {degree_out, weight_out, neighbour};
    assign m_axis_tuser = status;

endmodule

`default_nettype wire
